// File: design/kshb_pkg.sv
package kshb_pkg;

  // Sample and level width
  localparam int unsigned LEVEL_W = 12;

  // Hysteresis margin register
  localparam int unsigned MARGIN_W = 8;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd16;

  // Bin widths; rate and bit error bins span 128 codes, duration bins 64
  localparam int unsigned RATE_BIN_W = 4;
  localparam int unsigned DUR_BIN_W  = 5;

  // Result action codes
  typedef enum logic [1:0] {
    ACT_IDLE    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_NEXT    = 2'd2,
    ACT_DONE    = 2'd3
  } action_t;

endpackage

// File: design/knob_scan_hysteresis_binner.sv
// Knob scan hysteresis binner. Each poll item steps a five-phase scan: setup, drop duration,
// drop rate, bit error and current sense. Setup clamps the three knob levels to 0..2047, bins
// them (duration 32 bins, rate and bit error 16 bins each), pulses change flags and asks for a
// scan restart, whatever the poll carries. The knob phases replace their level only when the
// sample differs by more than cfg_data's margin; current sense stores the sample raw and ends
// the round. Polls without sample_ready outside setup change nothing and report idle. Every
// item gives exactly one result. Rate: one item per cycle; a result is registered the cycle after
// its item is accepted and sits in the output register, the only throttle on the input while
// out_ready is low. The user writes the margin via cfg_valid/cfg_data while idle; not enforced.
module knob_scan_hysteresis_binner
  import kshb_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [MARGIN_W-1:0]          cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_sample_ready,
  input  logic signed [LEVEL_W-1:0]    in_sample_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_action,
  output logic [RATE_BIN_W-1:0]        out_bit_error_bin,
  output logic [RATE_BIN_W-1:0]        out_dropout_rate_bin_out,
  output logic [DUR_BIN_W-1:0]         out_dropout_length_bin,
  output logic                         out_bit_error_changed,
  output logic                         out_dropout_changed,
  output logic signed [LEVEL_W-1:0]    out_current_reading
);

  typedef enum logic [2:0] {
    PH_SETUP = 3'd0,
    PH_DUR   = 3'd1,
    PH_RATE  = 3'd2,
    PH_ERR   = 3'd3,
    PH_CURR  = 3'd4
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [MARGIN_W-1:0]        margin_r;
  logic signed [LEVEL_W-1:0]  dur_level_r, dur_level_nxt;
  logic signed [LEVEL_W-1:0]  rate_level_r, rate_level_nxt;
  logic signed [LEVEL_W-1:0]  err_level_r, err_level_nxt;
  logic signed [LEVEL_W-1:0]  curr_level_r, curr_level_nxt;
  logic [RATE_BIN_W-1:0]      err_bin_r, err_bin_nxt;
  logic [RATE_BIN_W-1:0]      rate_bin_r, rate_bin_nxt;
  logic [DUR_BIN_W-1:0]       dur_bin_r, dur_bin_nxt;
  action_t                    action_nxt;
  logic                       err_chg_nxt, drop_chg_nxt;

  logic                       out_valid_r;
  action_t                    action_r;
  logic                       err_chg_r, drop_chg_r;
  logic                       in_fire;

  // Keep the old level unless the sample moves past the margin
  function automatic logic signed [LEVEL_W-1:0] hold_or_take(
    input logic signed [LEVEL_W-1:0] prev,
    input logic signed [LEVEL_W-1:0] smp,
    input logic [MARGIN_W-1:0]       margin
  );
    logic signed [LEVEL_W:0] diff;
    logic [LEVEL_W:0]        mag;
    diff = {prev[LEVEL_W-1], prev} - {smp[LEVEL_W-1], smp};
    mag  = diff[LEVEL_W] ? (LEVEL_W+1)'(-diff) : (LEVEL_W+1)'(diff);
    if (mag > (LEVEL_W+1)'(margin)) begin
      return smp;
    end
    return prev;
  endfunction

  // Clamp at zero and take the top bits of the 11-bit magnitude as the bin
  function automatic logic [RATE_BIN_W-1:0] rate_bin(input logic signed [LEVEL_W-1:0] lvl);
    return lvl[LEVEL_W-1] ? '0 : lvl[LEVEL_W-2 -: RATE_BIN_W];
  endfunction

  function automatic logic [DUR_BIN_W-1:0] dur_bin(input logic signed [LEVEL_W-1:0] lvl);
    return lvl[LEVEL_W-1] ? '0 : lvl[LEVEL_W-2 -: DUR_BIN_W];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Advance the scan for one item
  always_comb begin
    phase_nxt      = phase_r;
    dur_level_nxt  = dur_level_r;
    rate_level_nxt = rate_level_r;
    err_level_nxt  = err_level_r;
    curr_level_nxt = curr_level_r;
    err_bin_nxt    = err_bin_r;
    rate_bin_nxt   = rate_bin_r;
    dur_bin_nxt    = dur_bin_r;
    action_nxt     = ACT_IDLE;
    err_chg_nxt    = 1'b0;
    drop_chg_nxt   = 1'b0;
    unique case (phase_r)
      PH_DUR: begin
        if (in_sample_ready) begin
          dur_level_nxt = hold_or_take(dur_level_r, in_sample_value, margin_r);
          phase_nxt     = PH_RATE;
          action_nxt    = ACT_NEXT;
        end
      end
      PH_RATE: begin
        if (in_sample_ready) begin
          rate_level_nxt = hold_or_take(rate_level_r, in_sample_value, margin_r);
          phase_nxt      = PH_ERR;
          action_nxt     = ACT_NEXT;
        end
      end
      PH_ERR: begin
        if (in_sample_ready) begin
          err_level_nxt = hold_or_take(err_level_r, in_sample_value, margin_r);
          phase_nxt     = PH_CURR;
          action_nxt    = ACT_NEXT;
        end
      end
      PH_CURR: begin
        if (in_sample_ready) begin
          curr_level_nxt = in_sample_value;
          phase_nxt      = PH_SETUP;
          action_nxt     = ACT_DONE;
        end
      end
      default: begin
        // Setup: publish bins and restart the scan
        err_bin_nxt  = rate_bin(err_level_r);
        rate_bin_nxt = rate_bin(rate_level_r);
        dur_bin_nxt  = dur_bin(dur_level_r);
        err_chg_nxt  = err_bin_nxt != err_bin_r;
        drop_chg_nxt = (rate_bin_nxt != rate_bin_r) || (dur_bin_nxt != dur_bin_r);
        phase_nxt    = PH_DUR;
        action_nxt   = ACT_RESTART;
      end
    endcase
  end

  // Hold scan state, margin and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SETUP;
      margin_r     <= MARGIN_RESET;
      dur_level_r  <= '0;
      rate_level_r <= '0;
      err_level_r  <= '0;
      curr_level_r <= '0;
      err_bin_r    <= '0;
      rate_bin_r   <= '0;
      dur_bin_r    <= '0;
      out_valid_r  <= 1'b0;
      action_r     <= ACT_IDLE;
      err_chg_r    <= 1'b0;
      drop_chg_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        margin_r <= cfg_data;
      end
      if (in_fire) begin
        phase_r      <= phase_nxt;
        dur_level_r  <= dur_level_nxt;
        rate_level_r <= rate_level_nxt;
        err_level_r  <= err_level_nxt;
        curr_level_r <= curr_level_nxt;
        err_bin_r    <= err_bin_nxt;
        rate_bin_r   <= rate_bin_nxt;
        dur_bin_r    <= dur_bin_nxt;
        action_r     <= action_nxt;
        err_chg_r    <= err_chg_nxt;
        drop_chg_r   <= drop_chg_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid                = out_valid_r;
  assign out_action               = action_r;
  assign out_bit_error_bin        = err_bin_r;
  assign out_dropout_rate_bin_out = rate_bin_r;
  assign out_dropout_length_bin   = dur_bin_r;
  assign out_bit_error_changed    = err_chg_r;
  assign out_dropout_changed      = drop_chg_r;
  assign out_current_reading      = curr_level_r;

  // Change pulses only come with a setup publish
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_bit_error_changed || out_dropout_changed) |-> out_action == ACT_RESTART)
    else $error("change pulse without restart");

  // A setup item always publishes and moves to the duration phase
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_SETUP |=> out_action == ACT_RESTART && phase_r == PH_DUR)
    else $error("setup item did not restart scan");

  // A poll without a sample outside setup leaves the phase alone and reports idle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r != PH_SETUP && !in_sample_ready
      |=> out_action == ACT_IDLE && phase_r == $past(phase_r))
    else $error("empty poll changed state");

  // Every accepted item shows up as a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("accepted item produced no result");

endmodule
